// ----- src/cpair_pkg.sv -----
// Shared types and constants for the Cantor pair/unpair unit.
`timescale 1ns / 1ps

package cpair_pkg;

  localparam int unsigned CoordW        = 31;
  localparam int unsigned CodeW         = 63;
  localparam int unsigned OutW          = 32;
  localparam int unsigned RootW         = 32;
  localparam int unsigned RemW          = 64;
  localparam int unsigned CoordBitsDflt = 31;

  typedef enum logic {
    OP_PAIR   = 1'b0,
    OP_UNPAIR = 1'b1
  } op_e;

  typedef struct packed {
    op_e               operation;
    logic [CoordW-1:0] first_coord;
    logic [CoordW-1:0] second_coord;
    logic [CodeW-1:0]  code_in;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code_out;
    logic [OutW-1:0]  first_out;
    logic [OutW-1:0]  second_out;
  } out_item_t;

  // Square root pipeline word; pair items carry x+y in root and y in n.
  typedef struct packed {
    op_e              op;
    logic [CodeW-1:0] n;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  // Post-processing word: p, triangle number (or pair code) and n (or y).
  typedef struct packed {
    op_e              op;
    logic [RootW-1:0] p;
    logic [CodeW-1:0] t;
    logic [CodeW-1:0] n;
  } post_t;

endpackage

// ----- src/cpair_sqrt_stage.sv -----
// One registered stage of the integer square root: decides one root bit.
`timescale 1ns / 1ps

module cpair_sqrt_stage #(
  parameter int unsigned BIT = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  cpair_pkg::sqrt_t d_i,
  output logic             valid_o,
  output cpair_pkg::sqrt_t q_o
);

  localparam int unsigned TrialW = cpair_pkg::RemW + 2;

  logic [TrialW-1:0] trial;
  logic              take;
  cpair_pkg::sqrt_t  stage_d;
  cpair_pkg::sqrt_t  stage_q;
  logic              valid_q;

  assign trial = ({{(TrialW - cpair_pkg::RootW){1'b0}}, d_i.root} << (BIT + 1))
               | ({{(TrialW - 1){1'b0}}, 1'b1} << (2 * BIT));
  assign take  = ({2'b00, d_i.rem} >= trial);

  always_comb begin
    stage_d = d_i;
    if (d_i.op == cpair_pkg::OP_UNPAIR && take) begin
      stage_d.rem  = d_i.rem - trial[cpair_pkg::RemW-1:0];
      stage_d.root = d_i.root | (cpair_pkg::RootW'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign q_o     = stage_q;

endmodule

// ----- src/cantor_pair_unpair_unit.sv -----
// Cantor pair/unpair unit: top level with entry, square root chain and post stages.
`timescale 1ns / 1ps

// Every item passes 37 register stages: an entry register, 32 square root stages
// (one root bit each) and four stages for the triangle multiply, the correction
// and the subtracts. The pipeline takes one item per cycle while results are taken;
// a stalled output holds the whole chain, and the entry register still fills if it
// is empty.

module cantor_pair_unpair_unit #(
  parameter int unsigned COORD_BITS = cpair_pkg::CoordBitsDflt
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cpair_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cpair_pkg::out_item_t out_data_o
);

  localparam int unsigned Stages = cpair_pkg::RootW;
  localparam logic [cpair_pkg::CoordW:0] MaskWide =
    ({{cpair_pkg::CoordW{1'b0}}, 1'b1} << COORD_BITS) - {{cpair_pkg::CoordW{1'b0}}, 1'b1};
  localparam logic [cpair_pkg::CoordW-1:0] CoordMask = MaskWide[cpair_pkg::CoordW-1:0];

  logic advance;
  logic entry_en;

  logic [cpair_pkg::CoordW-1:0] x_m;
  logic [cpair_pkg::CoordW-1:0] y_m;
  logic [cpair_pkg::RootW-1:0]  sum;
  cpair_pkg::sqrt_t             entry_d;

  cpair_pkg::sqrt_t sq_data  [Stages+1];
  logic             sq_valid [Stages+1];

  logic [2*cpair_pkg::RootW:0] prod;
  logic                        gt;

  cpair_pkg::post_t     m1_d, m1_q, m2_d, m2_q, m3_d, m3_q;
  cpair_pkg::out_item_t out_d, out_q;
  logic                 v1_q, v2_q, v3_q, vo_q;

  assign advance    = !vo_q || out_ready_i;
  assign entry_en   = advance || !sq_valid[0];
  assign in_ready_o = entry_en;

  // Entry: mask coordinates, form x+y for pair, 2n for unpair.
  assign x_m = in_data_i.first_coord & CoordMask;
  assign y_m = in_data_i.second_coord & CoordMask;
  assign sum = {1'b0, x_m} + {1'b0, y_m};

  always_comb begin
    entry_d.op = in_data_i.operation;
    if (in_data_i.operation == cpair_pkg::OP_UNPAIR) begin
      entry_d.n    = in_data_i.code_in;
      entry_d.rem  = {in_data_i.code_in, 1'b0};
      entry_d.root = '0;
    end else begin
      entry_d.n    = {{(cpair_pkg::CodeW - cpair_pkg::CoordW){1'b0}}, y_m};
      entry_d.rem  = '0;
      entry_d.root = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid[0] <= 1'b0;
    end else if (entry_en) begin
      sq_valid[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_en) begin
      sq_data[0] <= entry_d;
    end
  end

  for (genvar k = 0; k < Stages; k++) begin : g_sqrt
    cpair_sqrt_stage #(
      .BIT(Stages - 1 - k)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .valid_i(sq_valid[k]),
      .d_i    (sq_data[k]),
      .valid_o(sq_valid[k+1]),
      .q_o    (sq_data[k+1])
    );
  end

  // Triangle number of the root (or of x+y).
  assign prod = {1'b0, sq_data[Stages].root} * ({1'b0, sq_data[Stages].root} + 1'b1);

  always_comb begin
    m1_d.op = sq_data[Stages].op;
    m1_d.p  = sq_data[Stages].root;
    m1_d.t  = prod[cpair_pkg::CodeW:1];
    m1_d.n  = sq_data[Stages].n;
  end

  // Correct the root down by one, or add y to form the pair code.
  assign gt = (m1_q.t > m1_q.n);

  always_comb begin
    m2_d = m1_q;
    if (m1_q.op == cpair_pkg::OP_UNPAIR) begin
      if (gt) begin
        m2_d.p = m1_q.p - 1'b1;
        m2_d.t = m1_q.t - {{(cpair_pkg::CodeW - cpair_pkg::RootW){1'b0}}, m1_q.p};
      end
    end else begin
      m2_d.t = m1_q.t + m1_q.n;
    end
  end

  always_comb begin
    m3_d = m2_q;
    if (m2_q.op == cpair_pkg::OP_UNPAIR) begin
      m3_d.n = {{(cpair_pkg::CodeW - cpair_pkg::OutW){1'b0}},
                m2_q.n[cpair_pkg::OutW-1:0] - m2_q.t[cpair_pkg::OutW-1:0]};
    end
  end

  always_comb begin
    if (m3_q.op == cpair_pkg::OP_UNPAIR) begin
      out_d.code_out   = '0;
      out_d.second_out = m3_q.n[cpair_pkg::OutW-1:0];
      out_d.first_out  = m3_q.p - m3_q.n[cpair_pkg::OutW-1:0];
    end else begin
      out_d.code_out   = m3_q.t;
      out_d.first_out  = '0;
      out_d.second_out = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (advance) begin
      v1_q <= sq_valid[Stages];
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      m3_q  <= m3_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/cpair_checker.sv -----
// Port-level assertions for the Cantor pair/unpair unit, bound to the top level.
`timescale 1ns / 1ps

module cpair_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input cpair_pkg::out_item_t out_data_o
);

  logic [cpair_pkg::OutW:0] xy_sum;

  assign xy_sum = {1'b0, out_data_o.first_out} + {1'b0, out_data_o.second_out};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("item changed while stalled");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held off without an output stall");

  a_pair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.code_out != '0
      |-> out_data_o.first_out == '0 && out_data_o.second_out == '0)
    else $error("pair item has nonzero coordinates");

  a_unpair_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !xy_sum[cpair_pkg::OutW])
    else $error("recovered coordinates exceed the root range");

endmodule

bind cantor_pair_unpair_unit cpair_checker u_cpair_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
